// ===== sv/flow_hash_source_port_defines.svh =====
// assertion macros for the flow hash source port block
// both expect clk in scope, the first also arst_n
`ifndef FLOW_HASH_SOURCE_PORT_DEFINES_SVH
`define FLOW_HASH_SOURCE_PORT_DEFINES_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define FHSP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("flow hash source port check failed");

// checked during reset too
`define FHSP_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("flow hash source port reset check failed");

`else

`define FHSP_ASSERT(label, prop)
`define FHSP_ASSERT_RST(label, prop)

`endif

`endif

// ===== sv/fhsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fhsp_pkg;

	localparam int WORD_W      = 32;
	localparam int PORT_W      = 16;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int MIX_WORDS   = 9;
	localparam int TAIL_WORDS  = 3;

	localparam logic [WORD_W-1:0] HASH_GOLDEN = 32'hdeadbeef;

	localparam logic [1:0]        PORT_MODE_RST  = 2'd0;
	localparam logic [WORD_W-1:0] HASH_SEED_RST  = 32'd4341;
	localparam logic [PORT_W-1:0] FIXED_PORT_RST = 16'd4341;

	localparam logic [3:0] IP_V4 = 4'd4;
	localparam logic [3:0] IP_V6 = 4'd6;

	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_SCTP = 8'd132;

	typedef enum logic [1:0] {
		MODE_FIXED    = 2'd0,
		MODE_SHORT    = 2'd1,
		MODE_LONG     = 2'd2,
		MODE_ADAPTIVE = 2'd3
	} port_mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PORT_MODE  = 2'd0,
		REG_HASH_SEED  = 2'd1,
		REG_FIXED_PORT = 2'd2
	} cfg_reg_t;

	// hash state plus whatever key words are still to be consumed
	typedef struct packed {
		logic                               bypass;
		logic [PORT_W-1:0]                  bypass_port;
		logic [1:0]                         nmix;
		logic [WORD_W-1:0]                  a;
		logic [WORD_W-1:0]                  b;
		logic [WORD_W-1:0]                  c;
		logic [MIX_WORDS-1:0][WORD_W-1:0]   key;
		logic [TAIL_WORDS-1:0][WORD_W-1:0]  tail;
	} hash_pipe_t;

	function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
		input int unsigned n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

endpackage

`default_nettype wire

// ===== sv/fhsp_key_build.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fhsp_key_build
	import fhsp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [1:0]        port_mode,
	input  wire logic [WORD_W-1:0] hash_seed,
	input  wire logic [PORT_W-1:0] fixed_port,
	input  wire logic [3:0]        ip_version,
	input  wire logic [63:0]       src_addr_hi,
	input  wire logic [63:0]       src_addr_lo,
	input  wire logic [63:0]       dst_addr_hi,
	input  wire logic [63:0]       dst_addr_lo,
	input  wire logic [7:0]        protocol,
	input  wire logic [WORD_W-1:0] port_word,
	input  wire logic              port_word_missing,
	output logic                   out_valid,
	output hash_pipe_t             out_pipe
);

	logic              valid_s1;
	hash_pipe_t        pipe_s1;
	hash_pipe_t        pipe_d;
	logic              is_v4;
	logic              hashed;
	logic              long_key;
	logic [WORD_W-1:0] proto_w;
	logic [WORD_W-1:0] key_len;

	always_comb begin
		is_v4    = (ip_version == IP_V4);
		hashed   = (port_mode != MODE_FIXED) && (is_v4 || ip_version == IP_V6);
		long_key = (port_mode == MODE_LONG) ||
			((port_mode == MODE_ADAPTIVE) &&
			 (protocol == PROTO_UDP || protocol == PROTO_TCP || protocol == PROTO_SCTP));
		proto_w  = {24'd0, protocol};

		pipe_d             = '0;
		pipe_d.bypass      = 1'b0;
		pipe_d.bypass_port = fixed_port;
		if (!hashed) begin
			pipe_d.bypass = 1'b1;
		end else if (long_key && port_word_missing) begin
			pipe_d.bypass      = 1'b1;
			pipe_d.bypass_port = '0;
		end

		if (is_v4) begin
			if (long_key) begin
				pipe_d.nmix    = 2'd1;
				pipe_d.key[0]  = src_addr_lo[31:0];
				pipe_d.key[1]  = dst_addr_lo[31:0];
				pipe_d.key[2]  = proto_w;
				pipe_d.tail[0] = port_word;
				key_len        = 32'd4;
			end else begin
				pipe_d.nmix    = 2'd0;
				pipe_d.tail[0] = src_addr_lo[31:0];
				pipe_d.tail[1] = dst_addr_lo[31:0];
				pipe_d.tail[2] = proto_w;
				key_len        = 32'd3;
			end
		end else begin
			pipe_d.key[0] = src_addr_hi[63:32];
			pipe_d.key[1] = src_addr_hi[31:0];
			pipe_d.key[2] = src_addr_lo[63:32];
			pipe_d.key[3] = src_addr_lo[31:0];
			pipe_d.key[4] = dst_addr_hi[63:32];
			pipe_d.key[5] = dst_addr_hi[31:0];
			if (long_key) begin
				pipe_d.nmix    = 2'd3;
				pipe_d.key[6]  = dst_addr_lo[63:32];
				pipe_d.key[7]  = dst_addr_lo[31:0];
				pipe_d.key[8]  = proto_w;
				pipe_d.tail[0] = port_word;
				key_len        = 32'd10;
			end else begin
				pipe_d.nmix    = 2'd2;
				pipe_d.tail[0] = dst_addr_lo[63:32];
				pipe_d.tail[1] = dst_addr_lo[31:0];
				pipe_d.tail[2] = proto_w;
				key_len        = 32'd9;
			end
		end

		pipe_d.a = HASH_GOLDEN + (key_len << 2) + hash_seed;
		pipe_d.b = pipe_d.a;
		pipe_d.c = pipe_d.a;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			pipe_s1 <= pipe_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_pipe  = pipe_s1;

endmodule

`default_nettype wire

// ===== sv/fhsp_mix_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fhsp_mix_round
	import fhsp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       in_valid,
	input  wire hash_pipe_t in_pipe,
	output logic            out_valid,
	output hash_pipe_t      out_pipe
);

	logic       valid_s1;
	logic       valid_s2;
	logic       act_s1;
	hash_pipe_t pipe_s1;
	hash_pipe_t pipe_s2;
	hash_pipe_t front_d;
	hash_pipe_t back_d;
	logic       active;

	// key add and first three mix steps; consumed words shift out
	always_comb begin
		active  = (in_pipe.nmix != 2'd0);
		front_d = in_pipe;
		if (active) begin
			front_d.a = in_pipe.a + in_pipe.key[0];
			front_d.b = in_pipe.b + in_pipe.key[1];
			front_d.c = in_pipe.c + in_pipe.key[2];
			front_d.a = (front_d.a - front_d.c) ^ rotl32(front_d.c, 4);
			front_d.c = front_d.c + front_d.b;
			front_d.b = (front_d.b - front_d.a) ^ rotl32(front_d.a, 6);
			front_d.a = front_d.a + front_d.c;
			front_d.c = (front_d.c - front_d.b) ^ rotl32(front_d.b, 8);
			front_d.b = front_d.b + front_d.a;
			front_d.key  = {{TAIL_WORDS{32'd0}}, in_pipe.key[MIX_WORDS-1:TAIL_WORDS]};
			front_d.nmix = in_pipe.nmix - 2'd1;
		end
	end

	// last three mix steps
	always_comb begin
		back_d = pipe_s1;
		if (act_s1) begin
			back_d.a = (back_d.a - back_d.c) ^ rotl32(back_d.c, 16);
			back_d.c = back_d.c + back_d.b;
			back_d.b = (back_d.b - back_d.a) ^ rotl32(back_d.a, 19);
			back_d.a = back_d.a + back_d.c;
			back_d.c = (back_d.c - back_d.b) ^ rotl32(back_d.b, 4);
			back_d.b = back_d.b + back_d.a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s1 <= front_d;
			act_s1  <= active;
			pipe_s2 <= back_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_pipe  = pipe_s2;

endmodule

`default_nettype wire

// ===== sv/fhsp_final.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fhsp_final
	import fhsp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire hash_pipe_t   in_pipe,
	output logic              out_valid,
	output logic [PORT_W-1:0] out_port
);

	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic [WORD_W-1:0] a_s1, b_s1, c_s1;
	logic [WORD_W-1:0] c_s2;
	logic              bypass_s1, bypass_s2;
	logic [PORT_W-1:0] bport_s1, bport_s2;
	logic [PORT_W-1:0] port_s3;
	logic [WORD_W-1:0] a1, b1, c1;
	logic [WORD_W-1:0] a2, b2, c2;
	logic [PORT_W-1:0] port_d;

	// tail words in, then the first four final steps
	always_comb begin
		a1 = in_pipe.a + in_pipe.tail[0];
		b1 = in_pipe.b + in_pipe.tail[1];
		c1 = in_pipe.c + in_pipe.tail[2];
		c1 = (c1 ^ b1) - rotl32(b1, 14);
		a1 = (a1 ^ c1) - rotl32(c1, 11);
		b1 = (b1 ^ a1) - rotl32(a1, 25);
		c1 = (c1 ^ b1) - rotl32(b1, 16);
	end

	// remaining three final steps
	always_comb begin
		a2 = (a_s1 ^ c_s1) - rotl32(c_s1, 4);
		b2 = (b_s1 ^ a2) - rotl32(a2, 14);
		c2 = (c_s1 ^ b2) - rotl32(b2, 24);
	end

	// fold the hash halves into the port, or pass the bypass port
	always_comb begin
		if (bypass_s2) begin
			port_d = bport_s2;
		end else begin
			port_d = c_s2[PORT_W-1:0] + c_s2[WORD_W-1:PORT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1      <= a1;
			b_s1      <= b1;
			c_s1      <= c1;
			bypass_s1 <= in_pipe.bypass;
			bport_s1  <= in_pipe.bypass_port;
			c_s2      <= c2;
			bypass_s2 <= bypass_s1;
			bport_s2  <= bport_s1;
			port_s3   <= port_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_port  = port_s3;

endmodule

`default_nettype wire

// ===== sv/flow_hash_source_port.sv =====
// pipeline: 1 key build stage, 3 mix rounds of 2 stages each, 2 final stages,
//   1 fold and output stage
// throughput: one item per cycle; the whole pipeline holds while out_stall is
//   high with a result waiting, so in_stall follows that condition
// reset: arst_n clears all valid bits and loads port_mode 0, hash_seed 4341
//   and fixed_port 4341; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

`include "flow_hash_source_port_defines.svh"

module flow_hash_source_port
	import fhsp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [3:0]             ip_version,
	input  wire logic [63:0]            src_addr_hi,
	input  wire logic [63:0]            src_addr_lo,
	input  wire logic [63:0]            dst_addr_hi,
	input  wire logic [63:0]            dst_addr_lo,
	input  wire logic [7:0]             protocol,
	input  wire logic [WORD_W-1:0]      port_word,
	input  wire logic                   port_word_missing,
	// output channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [PORT_W-1:0]           source_port
);

	// configuration registers
	logic [1:0]        port_mode_q;
	logic [WORD_W-1:0] hash_seed_q;
	logic [PORT_W-1:0] fixed_port_q;

	// pipeline advance: everything moves unless a finished result is held
	logic en;

	logic       valid_s1, valid_s3, valid_s5, valid_s7;
	hash_pipe_t pipe_s1, pipe_s3, pipe_s5, pipe_s7;

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_mode_q  <= PORT_MODE_RST;
			hash_seed_q  <= HASH_SEED_RST;
			fixed_port_q <= FIXED_PORT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PORT_MODE:  port_mode_q  <= cfg_data[1:0];
				REG_HASH_SEED:  hash_seed_q  <= cfg_data[WORD_W-1:0];
				REG_FIXED_PORT: fixed_port_q <= cfg_data[PORT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: pick the bypass port or lay out the key words and seed the state
	fhsp_key_build u_key_build (
		.clk               (clk),
		.arst_n            (arst_n),
		.en                (en),
		.in_valid          (in_valid),
		.port_mode         (port_mode_q),
		.hash_seed         (hash_seed_q),
		.fixed_port        (fixed_port_q),
		.ip_version        (ip_version),
		.src_addr_hi       (src_addr_hi),
		.src_addr_lo       (src_addr_lo),
		.dst_addr_hi       (dst_addr_hi),
		.dst_addr_lo       (dst_addr_lo),
		.protocol          (protocol),
		.port_word         (port_word),
		.port_word_missing (port_word_missing),
		.out_valid         (valid_s1),
		.out_pipe          (pipe_s1)
	);

	// stages 2 to 7: up to three mix rounds, a round passes through once the
	// key has no full three-word block left before the tail
	fhsp_mix_round u_mix_0 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.in_pipe   (pipe_s1),
		.out_valid (valid_s3),
		.out_pipe  (pipe_s3)
	);

	fhsp_mix_round u_mix_1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_pipe   (pipe_s3),
		.out_valid (valid_s5),
		.out_pipe  (pipe_s5)
	);

	fhsp_mix_round u_mix_2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.in_pipe   (pipe_s5),
		.out_valid (valid_s7),
		.out_pipe  (pipe_s7)
	);

	// stages 8 to 10: tail words, final mixing, half fold and output register
	fhsp_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s7),
		.in_pipe   (pipe_s7),
		.out_valid (out_valid),
		.out_port  (source_port)
	);

	// no result leaves while the block is in reset
	`FHSP_ASSERT_RST(a_reset_quiet, !arst_n |-> !out_valid)
	// all full key blocks are consumed by the last mix round
	`FHSP_ASSERT(a_mix_done, valid_s7 |-> pipe_s7.nmix == 2'd0)
	// a stalled result stays valid and keeps its port
	`FHSP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(source_port))

endmodule

`default_nettype wire

// ===== sim/flow_hash_source_port_test.sv =====
`timescale 1ns / 1ps

module flow_hash_source_port_test;
	import fhsp_pkg::*;

	// index past the register list, writes there must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	// pipeline is ten stages deep, leave some margin on top
	localparam int DRAIN_CYCLES = 20;
	// long receiver hold-off, well past the pipeline depth
	localparam int HOLD_CYCLES = 300;
	// cycles with no transfer on either side before the run is declared hung
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int REPORT_MAX = 10;

	// one packet header as it enters the block
	typedef struct packed {
		logic [3:0]  ver;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [7:0]  proto;
		logic [31:0] pw;
		logic        miss;
	} header_t;

	// directed row: register settings, header, and a typed port where it is obvious
	typedef struct packed {
		port_mode_t  mode;
		logic [31:0] seed;
		logic [15:0] fport;
		header_t     hdr;
		logic        typed;
		logic [15:0] port;
	} header_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [3:0]             ip_version;
	logic [63:0]            src_addr_hi;
	logic [63:0]            src_addr_lo;
	logic [63:0]            dst_addr_hi;
	logic [63:0]            dst_addr_lo;
	logic [7:0]             protocol;
	logic [WORD_W-1:0]      port_word;
	logic                   port_word_missing;
	logic                   out_valid;
	logic                   out_stall;
	logic [PORT_W-1:0]      source_port;

	flow_hash_source_port dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.ip_version        (ip_version),
		.src_addr_hi       (src_addr_hi),
		.src_addr_lo       (src_addr_lo),
		.dst_addr_hi       (dst_addr_hi),
		.dst_addr_lo       (dst_addr_lo),
		.protocol          (protocol),
		.port_word         (port_word),
		.port_word_missing (port_word_missing),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.source_port       (source_port)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register copies the port prediction runs on
	port_mode_t  mode_now  = MODE_FIXED;
	logic [31:0] seed_now  = HASH_SEED_RST;
	logic [15:0] fixed_now = FIXED_PORT_RST;

	logic [15:0] expected_ports[$];
	header_row_t header_plan[$];

	int  mismatches = 0;
	int  ports_checked = 0;
	int  headers_sent = 0;
	int  v4_sent = 0;
	int  v6_sent = 0;
	int  other_sent = 0;
	int  configs_loaded = 0;
	int  burst_left = 0;
	int  holds_done = 0;
	bit  hold_request = 0;

	// rotate left, built from a doubled word
	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	// word-oriented lookup3 over the first n key words
	function automatic logic [31:0] lookup3_hash(input logic [9:0][31:0] key, input int n,
		input logic [31:0] seed);
		logic [31:0] a, b, c;
		int p;
		int left;
		a = HASH_GOLDEN + (32'(n) << 2) + seed;
		b = a;
		c = a;
		p = 0;
		left = n;
		while (left > 3) begin
			a += key[p];
			b += key[p + 1];
			c += key[p + 2];
			a -= c; a ^= rol(c, 4);  c += b;
			b -= a; b ^= rol(a, 6);  a += c;
			c -= b; c ^= rol(b, 8);  b += a;
			a -= c; a ^= rol(c, 16); c += b;
			b -= a; b ^= rol(a, 19); a += c;
			c -= b; c ^= rol(b, 4);  b += a;
			left -= 3;
			p += 3;
		end
		if (left == 0)
			return c;
		if (left >= 3)
			c += key[p + 2];
		if (left >= 2)
			b += key[p + 1];
		a += key[p];
		c ^= b; c -= rol(b, 14);
		a ^= c; a -= rol(c, 11);
		b ^= a; b -= rol(a, 25);
		c ^= b; c -= rol(b, 16);
		a ^= c; a -= rol(c, 4);
		b ^= a; b -= rol(a, 14);
		c ^= b; c -= rol(b, 24);
		return c;
	endfunction

	// source port the block should give for one header under the current registers
	function automatic logic [15:0] predict_port(input header_t h);
		logic [9:0][31:0] key;
		int n;
		logic long_key;
		logic [31:0] sum;
		key = '0;
		n = 0;
		// fixed mode and unknown versions bypass the hash
		if (mode_now == MODE_FIXED || (h.ver != IP_V4 && h.ver != IP_V6))
			return fixed_now;
		if (h.ver == IP_V4) begin
			key[0] = h.src_lo[31:0];
			key[1] = h.dst_lo[31:0];
			n = 2;
		end else begin
			key[0] = h.src_hi[63:32];
			key[1] = h.src_hi[31:0];
			key[2] = h.src_lo[63:32];
			key[3] = h.src_lo[31:0];
			key[4] = h.dst_hi[63:32];
			key[5] = h.dst_hi[31:0];
			key[6] = h.dst_lo[63:32];
			key[7] = h.dst_lo[31:0];
			n = 8;
		end
		key[n] = {24'd0, h.proto};
		n++;
		case (mode_now)
			MODE_LONG: begin
				long_key = 1'b1;
			end
			MODE_ADAPTIVE: begin
				long_key = (h.proto == PROTO_UDP || h.proto == PROTO_TCP ||
					h.proto == PROTO_SCTP);
			end
			default: begin
				long_key = 1'b0;
			end
		endcase
		if (long_key) begin
			// long key wanted but the packet stops short of the port word
			if (h.miss)
				return 16'd0;
			key[n] = h.pw;
			n++;
		end
		sum = lookup3_hash(key, n, seed_now);
		// fold the two halves with a 16-bit wrap
		return sum[15:0] + sum[31:16];
	endfunction

	// header with random content, biased toward the versions and protocols that hash
	function automatic header_t random_header();
		header_t h;
		int pick;
		pick = $urandom_range(0, 9);
		h.ver = (pick < 4) ? IP_V4 : (pick < 8) ? IP_V6 : 4'($urandom_range(0, 15));
		h.src_hi = {$urandom, $urandom};
		h.src_lo = {$urandom, $urandom};
		h.dst_hi = {$urandom, $urandom};
		h.dst_lo = {$urandom, $urandom};
		// now and then an address at an extreme
		pick = $urandom_range(0, 15);
		if (pick == 0)
			h.src_lo = '1;
		else if (pick == 1)
			h.dst_lo = '0;
		pick = $urandom_range(0, 7);
		case (pick)
			0, 1:    h.proto = PROTO_UDP;
			2, 3:    h.proto = PROTO_TCP;
			4:       h.proto = PROTO_SCTP;
			default: h.proto = 8'($urandom_range(0, 255));
		endcase
		h.pw = $urandom;
		h.miss = ($urandom_range(0, 7) == 0);
		return h;
	endfunction

	task automatic plan_row(input port_mode_t mode, input logic [31:0] seed,
		input logic [15:0] fport, input logic [3:0] ver, input logic [63:0] shi,
		input logic [63:0] slo, input logic [63:0] dhi, input logic [63:0] dlo,
		input logic [7:0] proto, input logic [31:0] pw, input logic miss,
		input logic typed, input logic [15:0] port);
		header_row_t r;
		r.mode = mode;
		r.seed = seed;
		r.fport = fport;
		r.hdr = '{ver, shi, slo, dhi, dlo, proto, pw, miss};
		r.typed = typed;
		r.port = port;
		header_plan.push_back(r);
	endtask

	// one register write at the next edge, mirrored into the local copies;
	// the caller drops the write enable after its last write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_PORT_MODE:  mode_now  = port_mode_t'(data[1:0]);
			REG_HASH_SEED:  seed_now  = data;
			REG_FIXED_PORT: fixed_now = data[15:0];
			default: ;
		endcase
	endtask

	// stop offering, wait for every port to come back, then load all three registers
	task automatic load_config(input port_mode_t mode, input logic [31:0] seed,
		input logic [15:0] fport);
		in_valid <= 1'b0;
		while (expected_ports.size() != 0)
			@(posedge clk);
		@(posedge clk);
		// unused upper bits carry noise and must be dropped
		write_reg(REG_PORT_MODE, (32'($urandom) & ~32'h3) | {30'd0, mode});
		write_reg(REG_HASH_SEED, seed);
		write_reg(REG_FIXED_PORT, {16'($urandom), fport});
		cfg_wr_en <= 1'b0;
		configs_loaded++;
	endtask

	// offer one header, hold it until the transfer, then queue its port
	task automatic send_header(input header_t h, input logic typed, input logic [15:0] port);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid          <= 1'b1;
		ip_version        <= h.ver;
		src_addr_hi       <= h.src_hi;
		src_addr_lo       <= h.src_lo;
		dst_addr_hi       <= h.dst_hi;
		dst_addr_lo       <= h.dst_lo;
		protocol          <= h.proto;
		port_word         <= h.pw;
		port_word_missing <= h.miss;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_ports.push_back(typed ? port : predict_port(h));
		burst_left--;
		headers_sent++;
		if (h.ver == IP_V4)
			v4_sent++;
		else if (h.ver == IP_V6)
			v6_sent++;
		else
			other_sent++;
	endtask

	// receiver: stall style is redrawn at random on a tick counter, a requested hold-off wins
	initial begin : receiver
		int style;
		int tick;
		style = 0;
		tick = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (tick % 64 == 0)
				style = $urandom_range(0, 3);
			if (hold_request) begin
				// long stretch so the pipeline fills and in_stall rises
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 0;
				holds_done++;
			end else begin
				case (style)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= ($urandom_range(0, 9) < 6);
					default: out_stall <= (tick % 4 == 0);
				endcase
			end
		end
	end

	// compare every output transfer with the oldest expected port
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ports.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected transfer: source_port %h with nothing pending",
						source_port);
			end else begin
				want = expected_ports.pop_front();
				ports_checked++;
				if (source_port !== want) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("port mismatch at %0t: expected %h, got %h",
							$realtime, want, source_port);
				end
			end
		end
	end

	// watchdog: too many cycles with no transfer on either side
	always @(posedge clk) begin
		int idle;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle = 0;
		else
			idle++;
		if (idle >= IDLE_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d ports pending",
				idle, expected_ports.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		header_row_t r;
		port_mode_t  phase_modes[PHASES];
		logic [31:0] seed;
		logic [15:0] fport;
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_index         <= REG_PORT_MODE;
		cfg_data          <= '0;
		in_valid          <= 1'b0;
		ip_version        <= '0;
		src_addr_hi       <= '0;
		src_addr_lo       <= '0;
		dst_addr_hi       <= '0;
		dst_addr_lo       <= '0;
		protocol          <= '0;
		port_word         <= '0;
		port_word_missing <= 1'b0;

		// directed headers: reset registers, extremes, every mode and each bypass
		plan_row(MODE_FIXED, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '0, '0, '0, '0,
			8'h00, 32'h0, 1'b0, 1'b1, FIXED_PORT_RST);
		plan_row(MODE_FIXED, HASH_SEED_RST, FIXED_PORT_RST, IP_V6, '1, '1, '1, '1,
			8'hff, '1, 1'b1, 1'b1, FIXED_PORT_RST);
		plan_row(MODE_SHORT, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '0, '0, '0, '0,
			8'h00, 32'h0, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_SHORT, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '1, '1, '1, '1,
			8'hff, '1, 1'b1, 1'b0, 16'h0);
		plan_row(MODE_SHORT, HASH_SEED_RST, FIXED_PORT_RST, IP_V6, '0, '0, '0, '0,
			8'h00, 32'h0, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_SHORT, HASH_SEED_RST, FIXED_PORT_RST, IP_V6, '1, '1, '1, '1,
			8'hff, '1, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_SHORT, HASH_SEED_RST, FIXED_PORT_RST, 4'd0, '1, '1, '1, '1,
			PROTO_UDP, '1, 1'b0, 1'b1, FIXED_PORT_RST);
		plan_row(MODE_SHORT, HASH_SEED_RST, FIXED_PORT_RST, 4'd15, '1, '1, '1, '1,
			PROTO_TCP, '1, 1'b1, 1'b1, FIXED_PORT_RST);
		plan_row(MODE_LONG, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '1, '1, '1, '1,
			8'hff, '1, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_LONG, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '0, '0, '0, '0,
			8'h00, 32'h0, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_LONG, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '1, '1, '1, '1,
			PROTO_UDP, '1, 1'b1, 1'b1, 16'h0);
		plan_row(MODE_LONG, HASH_SEED_RST, FIXED_PORT_RST, IP_V6, '1, '1, '1, '1,
			8'hff, '1, 1'b1, 1'b1, 16'h0);
		plan_row(MODE_LONG, HASH_SEED_RST, FIXED_PORT_RST, IP_V6,
			64'h0123456789abcdef, 64'hfedcba9876543210, 64'h00ff00ff00ff00ff,
			64'hf0f0f0f0f0f0f0f0, PROTO_SCTP, 32'h12345678, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_LONG, HASH_SEED_RST, FIXED_PORT_RST, 4'd5, '1, '1, '1, '1,
			PROTO_TCP, '1, 1'b1, 1'b1, FIXED_PORT_RST);
		plan_row(MODE_ADAPTIVE, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '0,
			64'hc0a80001, '0, 64'h0a000001, PROTO_UDP, 32'h12b512b5, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_ADAPTIVE, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '0,
			64'hc0a80001, '0, 64'h0a000001, PROTO_TCP, 32'h0, 1'b1, 1'b1, 16'h0);
		plan_row(MODE_ADAPTIVE, HASH_SEED_RST, FIXED_PORT_RST, IP_V6,
			64'h20010db800000000, 64'h1, 64'h20010db800000000, 64'h2, PROTO_SCTP,
			32'hdeadbeef, 1'b0, 1'b0, 16'h0);
		// short key in adaptive mode ignores a missing port word
		plan_row(MODE_ADAPTIVE, HASH_SEED_RST, FIXED_PORT_RST, IP_V4, '0,
			64'hc0a80001, '0, 64'h0a000001, 8'd1, 32'h0, 1'b1, 1'b0, 16'h0);
		plan_row(MODE_ADAPTIVE, 32'h0, FIXED_PORT_RST, IP_V6, '1, '0, '0, '1,
			PROTO_UDP, 32'h80000001, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_ADAPTIVE, '1, 16'h0, 4'd7, '1, '1, '1, '1,
			PROTO_UDP, '1, 1'b0, 1'b1, 16'h0);
		plan_row(MODE_SHORT, '1, 16'h0, IP_V4, '0, '1, '0, '1,
			PROTO_TCP, '0, 1'b0, 1'b0, 16'h0);
		plan_row(MODE_FIXED, '1, 16'hffff, IP_V4, '1, '1, '1, '1,
			PROTO_UDP, '1, 1'b0, 1'b1, 16'hffff);
		plan_row(MODE_FIXED, '1, 16'h0, IP_V6, '0, '0, '0, '0,
			PROTO_TCP, '0, 1'b1, 1'b1, 16'h0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (header_plan[i]) begin
			r = header_plan[i];
			if (r.mode != mode_now || r.seed != seed_now || r.fport != fixed_now)
				load_config(r.mode, r.seed, r.fport);
			send_header(r.hdr, r.typed, r.port);
		end

		// a write past the register list, followed by hashing that must not notice it
		in_valid <= 1'b0;
		while (expected_ports.size() != 0)
			@(posedge clk);
		@(posedge clk);
		write_reg(REG_UNUSED, $urandom);
		cfg_wr_en <= 1'b0;

		// random phases, each under its own register setting
		phase_modes = '{MODE_SHORT, MODE_LONG, MODE_ADAPTIVE, MODE_FIXED,
			MODE_ADAPTIVE, MODE_LONG, MODE_SHORT, MODE_ADAPTIVE};
		for (int p = 0; p < PHASES; p++) begin
			seed  = (p == 1) ? 32'h0 : (p == 2) ? 32'hffffffff : $urandom;
			fport = (p == 3) ? 16'h0 : (p == 5) ? 16'hffff : 16'($urandom);
			load_config(phase_modes[p], seed, fport);
			// back pressure all the way to the input in one hashing phase
			if (p == 2)
				hold_request = 1;
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_header(random_header(), 1'b0, 16'h0);
		end

		in_valid <= 1'b0;
		while (expected_ports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d headers (%0d ipv4, %0d ipv6, %0d other versions) over %0d settings",
			headers_sent, v4_sent, v6_sent, other_sent, configs_loaded);
		$display("checked %0d ports, %0d long hold-offs, %0d mismatches",
			ports_checked, holds_done, mismatches);
		if (mismatches == 0 && expected_ports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
